// ===== rtl/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Key/value table package
// Shared sizes, action codes and the control bundle that the top level
// broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package kvt_pkg;

    // Table size and derived widths.
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Field widths.
    localparam int ACT_W = 2;
    localparam int KEY_W = 16;
    localparam int VAL_W = 32;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

    // Control broadcast from the sequencer to the cells.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic             ins_en;
        logic             del_en;
    } kvt_ctrl_t;

endpackage

// ===== rtl/kvt_cell.sv =====
// ----------------------------------------------------------------------------
// Key/value table storage cell
// Holds one key/value pair, compares it against the broadcast key, passes
// the match-seen flag and the read value up the row, and on a delete takes
// the pair of its upper neighbor.
// ----------------------------------------------------------------------------
module kvt_cell (
    input  logic                      aclk,
    input  logic [kvt_pkg::IDX_W-1:0] idx,
    input  kvt_pkg::kvt_ctrl_t        ctrl,
    input  logic [kvt_pkg::KEY_W-1:0] nbr_key,
    input  logic [kvt_pkg::VAL_W-1:0] nbr_value,
    input  logic                      seen_in,
    input  logic [kvt_pkg::VAL_W-1:0] rd_in,
    output logic [kvt_pkg::KEY_W-1:0] key_out,
    output logic [kvt_pkg::VAL_W-1:0] value_out,
    output logic                      seen_out,
    output logic [kvt_pkg::VAL_W-1:0] rd_out
);

    logic [kvt_pkg::KEY_W-1:0] key_reg;
    logic [kvt_pkg::VAL_W-1:0] value_reg;
    logic [kvt_pkg::CNT_W-1:0] pos;
    logic                      occupied;
    logic                      has_upper;
    logic                      match;

    // Position tests against the current entry count.
    assign pos       = kvt_pkg::CNT_W'(idx);
    assign occupied  = (pos < ctrl.count);
    assign has_upper = ((pos + kvt_pkg::CNT_W'(1)) < ctrl.count);
    assign match     = occupied && (key_reg == ctrl.key);

    // Keys in the table are unique, so an OR chain picks the single hit.
    assign seen_out  = seen_in | match;
    assign rd_out    = rd_in | (match ? value_reg : '0);
    assign key_out   = key_reg;
    assign value_out = value_reg;

    // Append at the first free slot, or close the gap left by a delete.
    always_ff @(posedge aclk) begin
        if (ctrl.ins_en && (pos == ctrl.count)) begin
            key_reg   <= ctrl.key;
            value_reg <= ctrl.value;
        end else if (ctrl.del_en && (seen_in || match) && has_upper) begin
            key_reg   <= nbr_key;
            value_reg <= nbr_value;
        end
    end

endmodule

// ===== rtl/key_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// Key/value table unit
// Compact associative table of up to CAPACITY key/value pairs in insertion
// order, built as a row of storage cells that all compare in parallel.
//
//   Channel  Direction  Ports                                  Transfer when
//   s_       in         action, key, data_in                   s_valid & s_ready
//   m_       out        hit, data_out, rejected, entry_count,  m_valid & m_ready
//                       is_empty, is_full
//   cfg_     in         wr_data (miss value)                   cfg_wr_en
//
// Each item is first captured from s_, then in the execute state the cell
// row compares, shifts or appends and the result register loads.
// The execute cycle waits while a previous result is still held on m_.
// s_ready is high whenever no item is in flight.
// Reset clears the entry count, the miss value and the handshake state;
// stored pairs need no clearing.
// ----------------------------------------------------------------------------
module key_value_table_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration
    input  logic                             cfg_wr_en,
    input  logic signed [kvt_pkg::VAL_W-1:0] cfg_wr_data,
    // Request channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [kvt_pkg::ACT_W-1:0]        s_action,
    input  logic [kvt_pkg::KEY_W-1:0]        s_key,
    input  logic signed [kvt_pkg::VAL_W-1:0] s_data_in,
    // Result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic signed [kvt_pkg::VAL_W-1:0] m_data_out,
    output logic                             m_rejected,
    output logic [kvt_pkg::CNT_W-1:0]        m_entry_count,
    output logic                             m_is_empty,
    output logic                             m_is_full
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    localparam logic [kvt_pkg::CNT_W-1:0] CNT_CAP = kvt_pkg::CNT_W'(kvt_pkg::CAPACITY);

    logic                        st_reg, st_next;
    logic [kvt_pkg::ACT_W-1:0]   act_reg;
    logic [kvt_pkg::KEY_W-1:0]   key_reg;
    logic [kvt_pkg::VAL_W-1:0]   din_reg;
    logic [kvt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [kvt_pkg::VAL_W-1:0]   miss_reg;

    logic                        mvalid_reg;
    logic                        hit_reg;
    logic [kvt_pkg::VAL_W-1:0]   dout_reg;
    logic                        rej_reg;
    logic [kvt_pkg::CNT_W-1:0]   cnt_out_reg;

    logic                        exec_go;
    logic                        hit;
    logic                        res_hit;
    logic                        full_now;
    logic                        ins_ok;
    logic                        rejected;
    logic [kvt_pkg::VAL_W-1:0]   data_res;
    kvt_pkg::kvt_ctrl_t          ctrl;

    logic [kvt_pkg::KEY_W-1:0]   key_c  [0:kvt_pkg::CAPACITY];
    logic [kvt_pkg::VAL_W-1:0]   val_c  [0:kvt_pkg::CAPACITY];
    logic                        seen_c [0:kvt_pkg::CAPACITY];
    logic [kvt_pkg::VAL_W-1:0]   rd_c   [0:kvt_pkg::CAPACITY];

    // Handshake and sequencing.
    assign s_ready = (st_reg == ST_IDLE);
    assign exec_go = (st_reg == ST_EXEC) && (!mvalid_reg || m_ready);

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (s_valid) st_next = ST_EXEC;
            ST_EXEC: if (exec_go) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // Ends of the cell chains.
    assign seen_c[0]                  = 1'b0;
    assign rd_c[0]                    = '0;
    assign key_c[kvt_pkg::CAPACITY]   = '0;
    assign val_c[kvt_pkg::CAPACITY]   = '0;

    // Decision logic on the outcome of the row compare.
    assign hit      = seen_c[kvt_pkg::CAPACITY];
    assign full_now = (count_reg >= CNT_CAP);
    assign ins_ok   = (act_reg == kvt_pkg::ACT_INSERT) && !hit && !full_now;
    assign rejected = (act_reg == kvt_pkg::ACT_INSERT) && !hit && full_now;
    assign data_res = ((act_reg == kvt_pkg::ACT_LOOKUP) && hit) ? rd_c[kvt_pkg::CAPACITY]
                                                                : miss_reg;

    // The unused action code is a no-op and never reports a hit.
    assign res_hit  = hit && (act_reg inside {kvt_pkg::ACT_LOOKUP, kvt_pkg::ACT_INSERT,
                                              kvt_pkg::ACT_DELETE});

    always_comb begin
        ctrl.key    = key_reg;
        ctrl.value  = din_reg;
        ctrl.count  = count_reg;
        ctrl.ins_en = exec_go && ins_ok;
        ctrl.del_en = exec_go && (act_reg == kvt_pkg::ACT_DELETE) && hit;
    end

    // Entry count after this action.
    always_comb begin
        count_next = count_reg;
        if (ins_ok) begin
            count_next = count_reg + kvt_pkg::CNT_W'(1);
        end else if ((act_reg == kvt_pkg::ACT_DELETE) && hit) begin
            count_next = count_reg - kvt_pkg::CNT_W'(1);
        end
    end

    // Row of storage cells.
    for (genvar i = 0; i < kvt_pkg::CAPACITY; i++) begin : g_cell
        kvt_cell u_cell (
            .aclk      (aclk),
            .idx       (kvt_pkg::IDX_W'(i)),
            .ctrl      (ctrl),
            .nbr_key   (key_c[i+1]),
            .nbr_value (val_c[i+1]),
            .seen_in   (seen_c[i]),
            .rd_in     (rd_c[i]),
            .key_out   (key_c[i]),
            .value_out (val_c[i]),
            .seen_out  (seen_c[i+1]),
            .rd_out    (rd_c[i+1])
        );
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            count_reg  <= '0;
            miss_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_wr_en) begin
                miss_reg <= cfg_wr_data;
            end
            if (exec_go) begin
                count_reg  <= count_next;
                mvalid_reg <= 1'b1;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    // Request capture and result register.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg <= s_action;
            key_reg <= s_key;
            din_reg <= s_data_in;
        end
        if (exec_go) begin
            hit_reg     <= res_hit;
            dout_reg    <= data_res;
            rej_reg     <= rejected;
            cnt_out_reg <= count_next;
        end
    end

    assign m_valid       = mvalid_reg;
    assign m_hit         = hit_reg;
    assign m_data_out    = dout_reg;
    assign m_rejected    = rej_reg;
    assign m_entry_count = cnt_out_reg;
    assign m_is_empty    = (cnt_out_reg == '0);
    assign m_is_full     = (cnt_out_reg == CNT_CAP);

endmodule

// ===== rtl/kvt_checker.sv =====
// ----------------------------------------------------------------------------
// Key/value table port checker
// Watches the ports of the top level and checks the result channel and the
// one-at-a-time request flow.
// ----------------------------------------------------------------------------
module kvt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_hit,
    input logic signed [kvt_pkg::VAL_W-1:0] m_data_out,
    input logic                             m_rejected,
    input logic [kvt_pkg::CNT_W-1:0]        m_entry_count,
    input logic                             m_is_empty,
    input logic                             m_is_full
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out) && $stable(m_entry_count))
        else $error("result changed while stalled");

    // Only one request is in flight, so a transfer drops ready.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // The flags agree with the count.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_entry_count == '0)) &&
                    (m_is_full == (m_entry_count == kvt_pkg::CNT_W'(kvt_pkg::CAPACITY))))
        else $error("empty or full flag disagrees with entry count");

    // A refused insert means the table was full and the key absent.
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_is_full && !m_hit)
        else $error("insert refused while not full or key present");

endmodule

bind key_value_table_unit kvt_checker u_kvt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_hit         (m_hit),
    .m_data_out    (m_data_out),
    .m_rejected    (m_rejected),
    .m_entry_count (m_entry_count),
    .m_is_empty    (m_is_empty),
    .m_is_full     (m_is_full)
);
